// File: hw/rtl/edl_pkg.sv
// Shared types, register indexes and helpers for the exposure-to-density LUT.
// Used by edl_mem, edl_div and rgb_exposure_to_density_lut_interp.
package edl_pkg;

	localparam int CH_N  = 3;
	localparam int VAL_W = 16;
	localparam int DVD_W = 33;   // dividend width of the serial divider
	localparam int DVS_W = 16;   // divisor width of the serial divider
	localparam int SUM_W = 35;   // width before the final saturation

	// configuration register indexes
	localparam logic [1:0] REG_KNOT_COUNT  = 2'd0;
	localparam logic [1:0] REG_GAMMA_RED   = 2'd1;
	localparam logic [1:0] REG_GAMMA_GREEN = 2'd2;
	localparam logic [1:0] REG_GAMMA_BLUE  = 2'd3;

	// one table entry: shared abscissa and three densities
	typedef struct packed {
		logic signed [VAL_W-1:0]     abscissa;
		logic [CH_N-1:0][VAL_W-1:0]  dens;
	} knot_t;

	// saturate to signed Q4.12
	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > 35'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -35'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/rgb_exposure_to_density_lut_interp.sv
// RGB log-exposure to density conversion through a piecewise-linear knot table.
// Depends on edl_pkg, edl_mem and edl_div.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low.
//   kind = 0 writes one knot (abscissa and three densities) in that same edge;
//   busy stays low and no result follows.
//   kind = 1 converts one pixel. busy rises and the channels are worked one
//   after another: gamma division, end clamps, binary search over the table,
//   then linear interpolation. When the blue channel is done, done pulses for
//   one cycle with density_red/green/blue valid; the receiver has no stall.
//   Per channel: the gamma quotient (divider start, one bit step per dividend
//   bit, then taking the quotient), the two end checks, the search steps (at
//   most floor(log2(n)) + 1 of them, n the knots in use), the two knot reads
//   and the interpolation quotient, and a step to move on. A channel clamped
//   at an end skips the search and the interpolation. done goes high in the
//   same cycle as busy falls. The pixel time is set by the single serial
//   divider and the single table read port, both shared by all three channels.
//   Registers are written through wr_en/wr_index/wr_data; the user must do so
//   only while busy is low, as the block itself does not enforce it.
//   Reset sets knot_count to 2 and all gammas to 1.0; the table is not
//   cleared and must be loaded before it is queried.
module rgb_exposure_to_density_lut_interp
	import edl_pkg::*;
#(
	parameter int MAX_KNOTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [7:0]         knot_index,
	input  logic signed [15:0] knot_log_exposure,
	input  logic signed [15:0] knot_density_red,
	input  logic signed [15:0] knot_density_green,
	input  logic signed [15:0] knot_density_blue,
	input  logic signed [15:0] exposure_red,
	input  logic signed [15:0] exposure_green,
	input  logic signed [15:0] exposure_blue,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data,
	output logic               done,
	output logic signed [15:0] density_red,
	output logic signed [15:0] density_green,
	output logic signed [15:0] density_blue
);

	localparam int IDX_W = $clog2(MAX_KNOTS);
	localparam int CNT_W = $clog2(MAX_KNOTS + 1);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_GDIV  = 12'b000000000010,
		ST_GWAIT = 12'b000000000100,
		ST_CHKLO = 12'b000000001000,
		ST_CHKHI = 12'b000000010000,
		ST_SRCH  = 12'b000000100000,
		ST_CMP   = 12'b000001000000,
		ST_RDK1  = 12'b000010000000,
		ST_MUL   = 12'b000100000000,
		ST_IDIV  = 12'b001000000000,
		ST_IWAIT = 12'b010000000000,
		ST_NEXT  = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [8:0]        knot_count_q;
	logic [CH_N-1:0][15:0] gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= 9'd2;
			gamma_q      <= {CH_N{16'd4096}};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_KNOT_COUNT:  knot_count_q <= wr_data[8:0];
				REG_GAMMA_RED:   gamma_q[0]   <= wr_data;
				REG_GAMMA_GREEN: gamma_q[1]   <= wr_data;
				REG_GAMMA_BLUE:  gamma_q[2]   <= wr_data;
				default:         ;
			endcase
		end
	end

	// knots in use, clamped to [1, MAX_KNOTS]
	logic [CNT_W-1:0] n_use;
	always_comb begin
		if (knot_count_q == '0) begin
			n_use = CNT_W'(1);
		end else if (32'(knot_count_q) > MAX_KNOTS) begin
			n_use = CNT_W'(MAX_KNOTS);
		end else begin
			n_use = CNT_W'(knot_count_q);
		end
	end

	// knot table
	logic             accept;
	logic             mem_we;
	knot_t            mem_wdata;
	logic [IDX_W-1:0] rd_addr;
	knot_t            rdata;

	assign accept = start && (state_q == ST_IDLE);
	assign mem_we = accept && !kind && (32'(knot_index) < MAX_KNOTS);
	assign mem_wdata = '{abscissa: knot_log_exposure,
		dens: {knot_density_blue, knot_density_green, knot_density_red}};

	edl_mem #(.DEPTH(MAX_KNOTS), .IDX_W(IDX_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (IDX_W'(knot_index)),
		.wdata (mem_wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// per-pixel working registers
	logic [1:0]                ch_q;
	logic [CH_N-1:0][15:0]     expo_q;
	logic signed [15:0]        x_q;
	logic [CNT_W-1:0]          lo_q, hi_q, mid_q, k_q;
	logic signed [15:0]        x0_q, y0_q;
	logic signed [33:0]        prod_q;
	logic signed [16:0]        den_q;
	logic                      neg_q;
	logic [CH_N-1:0][15:0]     res_q;
	logic                      done_q;

	// shared divider
	logic             div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;

	edl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// channel operands
	logic signed [15:0] e_cur;
	logic [15:0]        g_cur;
	logic [16:0]        e_mag;
	logic [15:0]        g_eff;
	logic [33:0]        prod_mag;
	logic [16:0]        den_mag;
	logic               neg_next;

	assign e_cur = signed'(expo_q[ch_q]);
	assign g_cur = gamma_q[ch_q];
	assign e_mag = e_cur[15] ? 17'(-{e_cur[15], e_cur}) : {1'b0, e_cur};
	assign g_eff = (g_cur == '0) ? 16'd1 : g_cur;
	assign prod_mag = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
	assign den_mag  = den_q[16] ? 17'(-den_q) : 17'(den_q);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = {DVD_W{1'b0}};
		div_dvs   = g_eff;
		neg_next  = e_cur[15];
		if (state_q == ST_GDIV) begin
			div_start = 1'b1;
			div_dvd   = DVD_W'({e_mag, 12'd0});
		end else if (state_q == ST_IDIV) begin
			div_start = 1'b1;
			div_dvd   = prod_mag[DVD_W-1:0];
			div_dvs   = den_mag[DVS_W-1:0];
			neg_next  = prod_q[33] ^ den_q[16];
		end
	end

	// signed quotient
	logic signed [SUM_W-1:0] q_signed;
	assign q_signed = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});

	// search helpers
	logic [CNT_W:0]     mid_sum;
	logic [CNT_W-1:0]   mid;
	logic [CNT_W-1:0]   k_clamp;
	logic signed [15:0] rd_abs;
	logic signed [15:0] rd_den;

	assign mid_sum = (CNT_W + 1)'(lo_q) + (CNT_W + 1)'(hi_q);
	assign mid     = mid_sum[CNT_W:1];
	assign rd_abs  = rdata.abscissa;
	assign rd_den  = signed'(rdata.dens[ch_q]);

	always_comb begin
		k_clamp = lo_q;
		if (k_clamp < CNT_W'(1)) begin
			k_clamp = CNT_W'(1);
		end
		if (k_clamp > n_use - 1'b1) begin
			k_clamp = n_use - 1'b1;
		end
	end

	// table read address
	always_comb begin
		unique case (state_q)
			ST_CHKLO: rd_addr = IDX_W'(n_use - 1'b1);
			ST_SRCH:  rd_addr = (lo_q < hi_q) ? IDX_W'(mid) : IDX_W'(k_clamp - 1'b1);
			ST_RDK1:  rd_addr = IDX_W'(k_q);
			default:  rd_addr = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && kind) begin
						ch_q    <= '0;
						state_q <= ST_GDIV;
					end
				end
				ST_GDIV:  state_q <= ST_GWAIT;
				ST_GWAIT: if (div_done) state_q <= ST_CHKLO;
				ST_CHKLO: state_q <= (x_q <= rd_abs) ? ST_NEXT : ST_CHKHI;
				ST_CHKHI: state_q <= (x_q >= rd_abs) ? ST_NEXT : ST_SRCH;
				ST_SRCH:  state_q <= (lo_q < hi_q) ? ST_CMP : ST_RDK1;
				ST_CMP:   state_q <= ST_SRCH;
				ST_RDK1:  state_q <= ST_MUL;
				ST_MUL:   state_q <= (rd_abs == x0_q) ? ST_NEXT : ST_IDIV;
				ST_IDIV:  state_q <= ST_IWAIT;
				ST_IWAIT: if (div_done) state_q <= ST_NEXT;
				ST_NEXT: begin
					if (ch_q == 2'd2) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_GDIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && kind) begin
			expo_q <= {exposure_blue, exposure_green, exposure_red};
		end
		if (div_start) begin
			neg_q <= neg_next;
		end
		unique case (state_q)
			ST_GWAIT: begin
				if (div_done) begin
					x_q <= sat16(q_signed);
				end
			end
			ST_CHKLO: begin
				if (x_q <= rd_abs) begin
					res_q[ch_q] <= rd_den;
				end
			end
			ST_CHKHI: begin
				if (x_q >= rd_abs) begin
					res_q[ch_q] <= rd_den;
				end
				lo_q <= '0;
				hi_q <= n_use;
			end
			ST_SRCH: begin
				mid_q <= mid;
				k_q   <= k_clamp;
			end
			ST_CMP: begin
				if (rd_abs > x_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + 1'b1;
				end
			end
			ST_RDK1: begin
				x0_q <= rd_abs;
				y0_q <= rd_den;
			end
			ST_MUL: begin
				if (rd_abs == x0_q) begin
					res_q[ch_q] <= y0_q;
				end
				prod_q <= (17'(rd_den) - 17'(y0_q)) * (17'(x_q) - 17'(x0_q));
				den_q  <= 17'(rd_abs) - 17'(x0_q);
			end
			ST_IWAIT: begin
				if (div_done) begin
					res_q[ch_q] <= sat16(SUM_W'(y0_q) + q_signed);
				end
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign density_red   = signed'(res_q[0]);
	assign density_green = signed'(res_q[1]);
	assign density_blue  = signed'(res_q[2]);

endmodule

// File: hw/rtl/edl_mem.sv
// Knot table: one write port, one read port with registered read data.
// Depends on edl_pkg for the entry type.
module edl_mem
	import edl_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  knot_t            wdata,
	input  logic [IDX_W-1:0] raddr,
	output knot_t            rdata
);

	knot_t mem [DEPTH];
	knot_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/edl_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on edl_pkg for operand widths.
module edl_div
	import edl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	// one trial subtraction per cycle
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: tb/rgb_exposure_to_density_lut_interp_tb.sv
// Self-checking bench for rgb_exposure_to_density_lut_interp: knot loads, pixel
// conversions and register writes, checked against an in-bench density predictor.
// Depends on edl_pkg and the RTL of the block.
module rgb_exposure_to_density_lut_interp_tb;
	import edl_pkg::*;

	localparam int KNOTS      = 256;
	localparam int SETTLE_CYC = 400;

	typedef enum logic [1:0] {OP_BEAT, OP_DRAIN, OP_WRITE} op_kind_e;
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef struct {
		op_kind_e                kind_op;
		logic                    kind;
		logic [7:0]              idx;
		logic signed [15:0]      absc;
		logic signed [15:0]      dens [3];
		logic signed [15:0]      expo [3];
		logic [1:0]              reg_idx;
		logic [15:0]             reg_data;
	} op_t;

	typedef struct {
		logic signed [15:0] d [3];
	} density_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	logic [7:0] knot_index = '0;
	logic signed [15:0] knot_log_exposure = '0;
	logic signed [15:0] knot_density_red = '0;
	logic signed [15:0] knot_density_green = '0;
	logic signed [15:0] knot_density_blue = '0;
	logic signed [15:0] exposure_red = '0;
	logic signed [15:0] exposure_green = '0;
	logic signed [15:0] exposure_blue = '0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [15:0] wr_data = '0;
	logic done;
	logic signed [15:0] density_red, density_green, density_blue;

	rgb_exposure_to_density_lut_interp dut (.*);

	always #5 clk = ~clk;

	op_t      pending_ops [$];
	density_t density_expected [$];
	int       fail_count = 0;
	logic     beat_taken = 1'b0;

	// predictor state
	logic [8:0]         pred_count;
	logic [15:0]        pred_gamma [3];
	logic signed [15:0] pred_absc [KNOTS];
	logic signed [15:0] pred_dens [KNOTS][3];

	// generator's view of the table, used to aim exposures at the curve
	logic signed [15:0] gen_absc [KNOTS];
	logic [15:0]        gen_gamma [3];
	int                 gen_count;

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic logic signed [15:0] density_of(logic signed [15:0] e, int ch);
		int unsigned n, lo, hi, mid, k;
		longint div, x, x0, x1, y0, y1, q;
		n = pred_count;
		if (n == 0) n = 1;
		if (n > KNOTS) n = KNOTS;
		div = (pred_gamma[ch] == 0) ? 1 : longint'(pred_gamma[ch]);
		x = clamp16((longint'(e) * 4096) / div);
		if (x <= pred_absc[0]) return pred_dens[0][ch];
		if (x >= pred_absc[n-1]) return pred_dens[n-1][ch];
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (pred_absc[mid] > x) hi = mid; else lo = mid + 1;
		end
		k = lo;
		if (k < 1) k = 1;
		if (k > n - 1) k = n - 1;
		x0 = pred_absc[k-1];
		x1 = pred_absc[k];
		y0 = pred_dens[k-1][ch];
		y1 = pred_dens[k][ch];
		if (x1 == x0) return 16'(y0);
		q = ((y1 - y0) * (x - x0)) / (x1 - x0);
		return 16'(clamp16(y0 + q));
	endfunction

	// monitor: register writes, accepted beats and results
	always @(posedge clk or negedge arst_n) begin
		density_t exp_d, got;
		if (!arst_n) begin
			beat_taken <= 1'b0;
			pred_count = 9'd2;
			for (int c = 0; c < 3; c++) pred_gamma[c] = 16'd4096;
		end else begin
			beat_taken <= start && !busy;
			if (done) begin
				got.d[0] = density_red;
				got.d[1] = density_green;
				got.d[2] = density_blue;
				if (density_expected.size() == 0) begin
					$error("unexpected result beat");
					fail_count++;
				end else begin
					exp_d = density_expected.pop_front();
					if (got.d[0] !== exp_d.d[0]) begin
						$error("density_red exp %0d got %0d", exp_d.d[0], got.d[0]);
						fail_count++;
					end
					if (got.d[1] !== exp_d.d[1]) begin
						$error("density_green exp %0d got %0d", exp_d.d[1], got.d[1]);
						fail_count++;
					end
					if (got.d[2] !== exp_d.d[2]) begin
						$error("density_blue exp %0d got %0d", exp_d.d[2], got.d[2]);
						fail_count++;
					end
				end
			end
			if (wr_en) begin
				if (wr_index == REG_KNOT_COUNT) pred_count = wr_data[8:0];
				else pred_gamma[wr_index - 1] = wr_data;
			end
			if (start && !busy) begin
				if (kind == KIND_LOAD) begin
					pred_absc[knot_index] = knot_log_exposure;
					pred_dens[knot_index][0] = knot_density_red;
					pred_dens[knot_index][1] = knot_density_green;
					pred_dens[knot_index][2] = knot_density_blue;
				end else begin
					exp_d.d[0] = density_of(exposure_red, 0);
					exp_d.d[1] = density_of(exposure_green, 1);
					exp_d.d[2] = density_of(exposure_blue, 2);
					density_expected.push_back(exp_d);
				end
			end
		end
	end

	// driver: bursts of beats with random gaps, drains before register writes
	int gap_cnt = 0;
	int burst_cnt = 4;
	int hold_cnt = 0;
	always @(negedge clk) begin
		logic n_start, n_wr;
		op_t op;
		n_start = 1'b0;
		n_wr = 1'b0;
		if (arst_n) begin
			if (start && !beat_taken) begin
				n_start = 1'b1;
			end else if (gap_cnt > 0) begin
				gap_cnt--;
			end else if (hold_cnt > 0) begin
				hold_cnt--;
			end else if (pending_ops.size() > 0) begin
				op = pending_ops[0];
				case (op.kind_op)
					OP_BEAT: begin
						void'(pending_ops.pop_front());
						n_start = 1'b1;
						kind <= op.kind;
						knot_index <= op.idx;
						knot_log_exposure <= op.absc;
						knot_density_red <= op.dens[0];
						knot_density_green <= op.dens[1];
						knot_density_blue <= op.dens[2];
						exposure_red <= op.expo[0];
						exposure_green <= op.expo[1];
						exposure_blue <= op.expo[2];
						if (--burst_cnt <= 0) begin
							burst_cnt = $urandom_range(1, 30);
							gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
						end
					end
					OP_DRAIN: begin
						if (density_expected.size() == 0 && !busy) begin
							void'(pending_ops.pop_front());
							hold_cnt = SETTLE_CYC;
						end
					end
					default: begin
						void'(pending_ops.pop_front());
						n_wr = 1'b1;
						wr_index <= op.reg_idx;
						wr_data <= op.reg_data;
					end
				endcase
			end
		end
		start <= n_start;
		wr_en <= n_wr;
	end

	function automatic logic signed [15:0] rand16();
		return 16'($urandom);
	endfunction

	task automatic add_write(logic [1:0] ri, logic [15:0] val);
		op_t op;
		op.kind_op = OP_DRAIN;
		pending_ops.push_back(op);
		op.kind_op = OP_WRITE;
		op.reg_idx = ri;
		op.reg_data = val;
		pending_ops.push_back(op);
		if (ri == REG_KNOT_COUNT) begin
			gen_count = val[8:0];
			if (gen_count == 0) gen_count = 1;
			if (gen_count > KNOTS) gen_count = KNOTS;
		end else begin
			gen_gamma[ri - 1] = val;
		end
	endtask

	task automatic add_load(int i, logic signed [15:0] a);
		op_t op;
		op.kind_op = OP_BEAT;
		op.kind = KIND_LOAD;
		op.idx = 8'(i);
		op.absc = a;
		for (int c = 0; c < 3; c++) begin
			op.dens[c] = rand16();
			op.expo[c] = rand16();
		end
		gen_absc[i] = a;
		pending_ops.push_back(op);
	endtask

	task automatic add_pixel(logic signed [15:0] er, logic signed [15:0] eg,
			logic signed [15:0] eb);
		op_t op;
		op.kind_op = OP_BEAT;
		op.kind = KIND_PIXEL;
		op.idx = 8'($urandom);
		op.absc = rand16();
		for (int c = 0; c < 3; c++) op.dens[c] = rand16();
		op.expo[0] = er;
		op.expo[1] = eg;
		op.expo[2] = eb;
		pending_ops.push_back(op);
	endtask

	// curve shapes: 0 ascending, 1 ascending with flat runs, 2 unsorted
	task automatic load_curve(int m, int shape);
		longint a;
		int step;
		step = 65535 / (m + 1);
		a = -32768 + longint'($urandom_range(0, step));
		for (int i = 0; i < m; i++) begin
			if (shape == 2) begin
				add_load(i, rand16());
			end else begin
				add_load(i, 16'(clamp16(a)));
				if (shape == 1 && $urandom_range(0, 2) == 0) a = a;
				else a = a + longint'($urandom_range(1, step));
			end
		end
	endtask

	// exposure aimed near the curve for one channel
	function automatic logic signed [15:0] pick_exposure(int ch);
		longint x;
		case ($urandom_range(0, 3))
			0: return rand16();
			1: x = gen_absc[$urandom_range(0, gen_count - 1)];
			default: x = gen_absc[0] + longint'($urandom_range(0, 65535)) *
				(longint'(gen_absc[gen_count-1]) - gen_absc[0]) / 65535;
		endcase
		x = x + longint'($urandom_range(0, 4)) - 2;
		return 16'(clamp16(x * longint'(gen_gamma[ch]) / 4096));
	endfunction

	function automatic logic [15:0] pick_gamma();
		case ($urandom_range(0, 5))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return 16'd4096;
			3: return 16'd0;
			default: return $urandom_range(1024, 16384);
		endcase
	endfunction

	initial begin
		int m;
		gen_count = 2;
		for (int c = 0; c < 3; c++) gen_gamma[c] = 16'd4096;

		// directed: full table, then ends, knots and register corner cases
		load_curve(KNOTS, 0);
		add_pixel(16'sh8000, 16'sh7FFF, 16'sh0000);
		add_pixel(gen_absc[0], gen_absc[1],
			16'((longint'(gen_absc[0]) + gen_absc[1]) / 2));
		add_pixel(gen_absc[1] - 1, gen_absc[0] + 1, 16'sh7FFF);
		add_write(REG_KNOT_COUNT, 16'd256);
		add_pixel(16'sh8000, gen_absc[100], gen_absc[255] - 1);
		add_write(REG_KNOT_COUNT, 16'd1);
		add_pixel(16'sh8000, 16'sh7FFF, 16'sh0000);
		add_write(REG_KNOT_COUNT, 16'd0);
		add_pixel(16'sh1234, 16'shF000, 16'sh0000);
		add_write(REG_KNOT_COUNT, 16'd511);
		add_write(REG_GAMMA_RED, 16'd0);
		add_write(REG_GAMMA_GREEN, 16'hFFFF);
		add_write(REG_GAMMA_BLUE, 16'd1);
		add_pixel(16'sh0001, 16'sh7FFF, 16'shFFFF);
		add_pixel(16'sh0000, 16'sh8000, 16'sh0000);
		load_curve(4, 1);
		load_curve(3, 2);
		add_write(REG_KNOT_COUNT, 16'd3);
		add_pixel(pick_exposure(0), pick_exposure(1), pick_exposure(2));
		add_pixel(rand16(), rand16(), rand16());

		// random phases: new settings, reload the knots in use, then pixels with occasional knot loads
		for (int ph = 0; ph < 8; ph++) begin
			m = (ph == 7) ? KNOTS : $urandom_range(2, 24);
			add_write(REG_KNOT_COUNT, 16'(m));
			for (int c = 0; c < 3; c++) add_write(2'(REG_GAMMA_RED + c), pick_gamma());
			load_curve(m, (ph % 3 == 2) ? $urandom_range(0, 2) : ph % 2);
			for (int i = 0; i < 160; i++) begin
				if ($urandom_range(0, 9) == 0)
					add_load($urandom_range(0, 255),
						16'((longint'(gen_absc[0]) + gen_absc[m-1]) / 2));
				else
					add_pixel(pick_exposure(0), pick_exposure(1), pick_exposure(2));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_ops.size() > 0 || start || density_expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#60000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: rgb_exposure_to_density_lut_interp.f
hw/rtl/edl_pkg.sv
hw/rtl/edl_mem.sv
hw/rtl/edl_div.sv
hw/rtl/rgb_exposure_to_density_lut_interp.sv
tb/rgb_exposure_to_density_lut_interp_tb.sv
